// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms of concurrent assertions for the slot pool RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge outside reset
`define RBSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// check that also holds across reset
`define RBSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/rbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool package
// Field widths, codes and shared types of the receive buffer slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsp_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 16;
    localparam int HDR_W  = 12;
    localparam int IDX_W  = 5;
    localparam int MAP_W  = 32;

    localparam logic [HDR_W-1:0] HEADER_RESET = 12'd64;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_TAKE  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_ADDR  = 3'd3,
        ST_NONE      = 3'd4
    } t_status;

    typedef enum logic {
        CFG_POOL_BASE = 1'b0,
        CFG_HEADER    = 1'b1
    } t_cfg_reg;

    // free address decode: inside the pool, and the slot it falls in
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_free_dec;

    // outcome of one word against the slot maps
    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] idx;
    } t_grant;

endpackage

`default_nettype wire

// ----- src/rbsp_addr_decode.sv -----
// ----------------------------------------------------------------------------
// Free address decode
// Range check of a byte address against the pool and the slot that holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsp_addr_decode #(
    parameter int SLOTS      = 32,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic [rbsp_pkg::ADDR_W-1:0] i_address,
    input  wire logic [rbsp_pkg::ADDR_W-1:0] i_pool_base,
    output rbsp_pkg::t_free_dec              o_dec
);

    localparam int AW = rbsp_pkg::ADDR_W;
    localparam int IW = rbsp_pkg::IDX_W;
    localparam logic [AW:0] SPAN = (AW+1)'(SLOTS * SLOT_BYTES);

    logic [AW:0]   diff;
    logic [IW-1:0] idx;

    // the top bit is the borrow: address below the base
    assign diff = {1'b0, i_address} - {1'b0, i_pool_base};

    // slot boundaries rise with k, so the last boundary passed wins
    always_comb begin
        idx = '0;
        for (int k = 1; k < SLOTS; k++) begin
            if (diff[AW-1:0] >= AW'(k * SLOT_BYTES)) begin
                idx = IW'(k);
            end
        end
    end

    assign o_dec.hit = !diff[AW] && (diff < SPAN);
    assign o_dec.idx = idx;

endmodule

`default_nettype wire

// ----- src/rbsp_slot_maps.sv -----
// ----------------------------------------------------------------------------
// Slot maps
// In-use and pending bitmaps with the allocate, free and take-next decisions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rbsp_slot_maps #(
    parameter int SLOTS      = 32,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire rbsp_pkg::t_action          i_action,
    input  wire logic [rbsp_pkg::LEN_W-1:0] i_length,
    input  wire logic [rbsp_pkg::HDR_W-1:0] i_header,
    input  wire rbsp_pkg::t_free_dec        i_free,
    output rbsp_pkg::t_grant                o_grant
);

    localparam int IW  = rbsp_pkg::IDX_W;
    localparam int SZW = rbsp_pkg::LEN_W + 1;
    localparam logic [SZW-1:0] SLOT_SIZE = SZW'(SLOT_BYTES);

    logic [SLOTS-1:0] r_used, n_used;
    logic [SLOTS-1:0] r_pend, n_pend;

    logic [SLOTS-1:0] free_bits;
    logic [SLOTS-1:0] free_hot;
    logic [SLOTS-1:0] pend_hot;
    logic [SLOTS-1:0] addr_hot;
    logic [IW-1:0]    free_idx;
    logic [IW-1:0]    pend_idx;
    logic [SZW-1:0]   need;
    logic             too_large;
    rbsp_pkg::t_grant grant;

    assign free_bits = ~r_used;
    assign need      = SZW'(i_length) + SZW'(i_header);
    assign too_large = need > SLOT_SIZE;

    // isolate the lowest set bit
    assign free_hot = free_bits & (~free_bits + SLOTS'(1));
    assign pend_hot = r_pend & (~r_pend + SLOTS'(1));

    always_comb begin
        free_idx = '0;
        pend_idx = '0;
        addr_hot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = IW'(i);
            end
            if (r_pend[i]) begin
                pend_idx = IW'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            addr_hot[i] = (i_free.idx == IW'(i));
        end
    end

    always_comb begin
        grant.status = rbsp_pkg::ST_OK;
        grant.idx    = '0;
        n_used       = r_used;
        n_pend       = r_pend;
        case (i_action)
            rbsp_pkg::ACT_ALLOC: begin
                if (too_large) begin
                    grant.status = rbsp_pkg::ST_TOO_LARGE;
                end else if (free_bits == '0) begin
                    grant.status = rbsp_pkg::ST_FULL;
                end else begin
                    grant.idx = free_idx;
                    n_used    = r_used | free_hot;
                    n_pend    = r_pend | free_hot;
                end
            end
            rbsp_pkg::ACT_FREE: begin
                if (!i_free.hit) begin
                    grant.status = rbsp_pkg::ST_BAD_ADDR;
                end else begin
                    grant.idx = i_free.idx;
                    n_used    = r_used & ~addr_hot;
                end
            end
            default: begin
                // take next; the unused code lands here too
                if (r_pend == '0) begin
                    grant.status = rbsp_pkg::ST_NONE;
                end else begin
                    grant.idx = pend_idx;
                    n_used    = r_used & ~pend_hot;
                    n_pend    = r_pend & ~pend_hot;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_pend <= '0;
        end else if (i_go) begin
            r_used <= n_used;
            r_pend <= n_pend;
        end
    end

    assign o_grant = grant;

    `RBSP_ASSERT_ALWAYS(a_maps_clear_after_reset,
        !i_rst_n |=> (r_used == '0) && (r_pend == '0),
        "slot maps not clear after reset")
    `RBSP_ASSERT(a_refusal_keeps_maps,
        i_go && (grant.status != rbsp_pkg::ST_OK) |=> $stable(r_used) && $stable(r_pend),
        "refused word changed the slot maps")
    `RBSP_ASSERT(a_alloc_marks_slot,
        i_go && (i_action == rbsp_pkg::ACT_ALLOC) && (grant.status == rbsp_pkg::ST_OK)
            |=> ((r_used & $past(free_hot)) != '0) && ((r_pend & $past(free_hot)) != '0),
        "allocated slot not marked in use and pending")

endmodule

`default_nettype wire

// ----- src/receive_buffer_slot_pool.sv -----
// ----------------------------------------------------------------------------
// Receive buffer slot pool
// Allocates, frees and hands on fixed-size receive slots tracked by bitmaps.
// ----------------------------------------------------------------------------
//  channel  | direction | data                         | user
//  ---------+-----------+------------------------------+-------------
//  s (req)  | in        | length[15:0], address[47:16] | action[1:0]
//  m (res)  | out       | slot_index[4:0],             | status[2:0]
//           |           | slot_address[36:5]           |
//  cfg      | in        | index 0 pool_base, 1 header_bytes
//
//  One word per cycle sustained while m is ready; each word passes the input
//  register, then the result register after the map update.
//  The slot maps see one word a cycle, so each word observes every earlier one.
//  A stall on m holds the result register, then the input register, then s.
//  Reset clears both maps and the handshake state; pool_base to 0, header to 64.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module receive_buffer_slot_pool #(
    parameter int SLOTS      = 32,
    parameter int SLOT_BYTES = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // length[15:0], address[47:16]
    input  wire logic [1:0]  i_s_tuser,   // action[1:0]
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // slot_index[4:0], slot_address[36:5], zero
    output logic [2:0]       o_m_tuser,   // status[2:0]
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = rbsp_pkg::ADDR_W;
    localparam int LW = rbsp_pkg::LEN_W;
    localparam int HW = rbsp_pkg::HDR_W;
    localparam int IW = rbsp_pkg::IDX_W;

    logic              r_in_valid;
    rbsp_pkg::t_action r_action;
    logic [LW-1:0]     r_length;
    logic [AW-1:0]     r_address;

    logic              r_out_valid;
    rbsp_pkg::t_status r_status;
    logic [IW-1:0]     r_idx;
    logic [AW-1:0]     r_slot_addr;

    logic [AW-1:0]     r_pool_base;
    logic [HW-1:0]     r_header;

    logic                stage_go;
    logic                in_take;
    rbsp_pkg::t_free_dec free_dec;
    rbsp_pkg::t_grant    grant;
    logic [AW-1:0]       slot_off;
    logic [AW-1:0]       n_slot_addr;

    // refuse words while reset is held
    assign stage_go   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_valid || stage_go);
    assign in_take    = i_s_tvalid && o_s_tready;

    rbsp_addr_decode #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_addr_decode (
        .i_address   (r_address),
        .i_pool_base (r_pool_base),
        .o_dec       (free_dec)
    );

    rbsp_slot_maps #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_slot_maps (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (stage_go),
        .i_action (r_action),
        .i_length (r_length),
        .i_header (r_header),
        .i_free   (free_dec),
        .o_grant  (grant)
    );

    // address wraps modulo 2^32; zero unless the word succeeded
    assign slot_off    = AW'(grant.idx) * AW'(SLOT_BYTES);
    assign n_slot_addr = (grant.status == rbsp_pkg::ST_OK) ? r_pool_base + slot_off : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (stage_go) begin
                r_in_valid <= 1'b0;
            end
            if (stage_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action  <= rbsp_pkg::t_action'(i_s_tuser);
            r_length  <= i_s_tdata[LW-1:0];
            r_address <= i_s_tdata[LW+AW-1:LW];
        end
        if (stage_go) begin
            r_status    <= grant.status;
            r_idx       <= grant.idx;
            r_slot_addr <= n_slot_addr;
        end
    end

    // configuration
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_header    <= rbsp_pkg::HEADER_RESET;
        end else if (i_cfg_valid) begin
            unique case (rbsp_pkg::t_cfg_reg'(i_cfg_index))
                rbsp_pkg::CFG_POOL_BASE: r_pool_base <= i_cfg_data;
                rbsp_pkg::CFG_HEADER:    r_header    <= i_cfg_data[HW-1:0];
                default:                 r_header    <= r_header;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_slot_addr, r_idx};
    assign o_m_tuser  = r_status;

    `RBSP_ASSERT(a_refusal_zero_payload,
        r_out_valid && (r_status != rbsp_pkg::ST_OK) |-> (r_idx == '0) && (r_slot_addr == '0),
        "refused result carries a slot")
    `RBSP_ASSERT(a_empty_output_takes_word,
        !r_out_valid |-> o_s_tready,
        "request side stalled with the result register empty")

endmodule

`default_nettype wire

// ----- tb/tb_receive_buffer_slot_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool testbench
// Drives allocate, free and take-next words into the receive buffer slot pool
// and checks every result word against a bitmap model kept alongside or, for
// marked rows of the short hand-checked table sent first, the row's own word.
// Random phases follow, each under its own pool base and header size, with
// stalls on both streams and one long result-side hold that backs the pool up.
// ----------------------------------------------------------------------------

module tb_receive_buffer_slot_pool;

    localparam int SLOTS          = 32;
    localparam int SLOT_BYTES     = 2048;
    localparam int RESULT_LATENCY = 2;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int RUN_LIMIT_NS   = 4_000_000;

    // spare action code, decoded by the block as take next
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        rbsp_pkg::t_status           status;
        logic [rbsp_pkg::IDX_W-1:0]  idx;
        logic [rbsp_pkg::ADDR_W-1:0] addr;
    } t_slot_result;

    typedef struct packed {
        logic [1:0]                  action;
        logic [rbsp_pkg::LEN_W-1:0]  length;
        logic [rbsp_pkg::ADDR_W-1:0] address;
    } t_request;

    typedef struct packed {
        logic                        use_row;
        logic [1:0]                  action;
        logic [rbsp_pkg::LEN_W-1:0]  length;
        logic [rbsp_pkg::ADDR_W-1:0] address;
        t_slot_result                want;
    } t_row;

    typedef struct {
        bit           use_row;
        t_slot_result row_result;
    } t_override;

    // default config: base 0, header 64, so 1984 bytes is the largest fit
    localparam t_row DIRECTED_ROWS [20] = '{
        '{1'b1, rbsp_pkg::ACT_TAKE,  16'd0,    32'd0,
          '{rbsp_pkg::ST_NONE,      5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_ALLOC, 16'd0,    32'hFFFF_FFFF,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_ALLOC, 16'd1984, 32'd0,
          '{rbsp_pkg::ST_OK,        5'd1,  32'd2048}},
        '{1'b1, rbsp_pkg::ACT_ALLOC, 16'd1985, 32'd0,
          '{rbsp_pkg::ST_TOO_LARGE, 5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_ALLOC, 16'hFFFF, 32'd0,
          '{rbsp_pkg::ST_TOO_LARGE, 5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_FREE,  16'hFFFF, 32'd65536,
          '{rbsp_pkg::ST_BAD_ADDR,  5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_FREE,  16'd0,    32'hFFFF_FFFF,
          '{rbsp_pkg::ST_BAD_ADDR,  5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_FREE,  16'd0,    32'd2053,
          '{rbsp_pkg::ST_OK,        5'd1,  32'd2048}},
        '{1'b1, rbsp_pkg::ACT_FREE,  16'd0,    32'd2048,
          '{rbsp_pkg::ST_OK,        5'd1,  32'd2048}},
        '{1'b1, rbsp_pkg::ACT_TAKE,  16'hFFFF, 32'hFFFF_FFFF,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b1, ACT_SPARE,           16'd0,    32'd0,
          '{rbsp_pkg::ST_OK,        5'd1,  32'd2048}},
        '{1'b1, ACT_SPARE,           16'd0,    32'd0,
          '{rbsp_pkg::ST_NONE,      5'd0,  32'd0}},
        '{1'b1, rbsp_pkg::ACT_FREE,  16'd0,    32'd65535,
          '{rbsp_pkg::ST_OK,        5'd31, 32'd63488}},
        '{1'b1, rbsp_pkg::ACT_FREE,  16'd0,    32'd0,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b0, rbsp_pkg::ACT_ALLOC, 16'd1000, 32'd0,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b0, rbsp_pkg::ACT_ALLOC, 16'd500,  32'd0,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b0, rbsp_pkg::ACT_FREE,  16'd0,    32'd2047,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b0, rbsp_pkg::ACT_ALLOC, 16'd7,    32'd0,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b0, rbsp_pkg::ACT_TAKE,  16'd0,    32'd0,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}},
        '{1'b0, rbsp_pkg::ACT_TAKE,  16'd0,    32'd0,
          '{rbsp_pkg::ST_OK,        5'd0,  32'd0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // length[15:0], address[47:16]
    logic [1:0]  i_s_tuser;   // action[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // slot_index[4:0], slot_address[36:5], zero
    logic [2:0]  o_m_tuser;   // status[2:0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    // bitmap model of the pool
    logic [rbsp_pkg::MAP_W-1:0]  mdl_used    = '0;
    logic [rbsp_pkg::MAP_W-1:0]  mdl_pending = '0;
    logic [rbsp_pkg::ADDR_W-1:0] mdl_base    = '0;
    logic [rbsp_pkg::HDR_W-1:0]  mdl_header  = rbsp_pkg::HEADER_RESET;

    t_slot_result expected_results[$];
    t_override    row_overrides[$];

    int errors      = 0;
    int words_sent  = 0;
    int cfg_writes  = 0;
    int status_seen [8];
    bit calm        = 1'b0;
    bit hold_sink   = 1'b0;

    receive_buffer_slot_pool #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int lowest_one(input logic [rbsp_pkg::MAP_W-1:0] bits);
        for (int i = 0; i < SLOTS; i++) begin
            if (bits[i]) return i;
        end
        return -1;
    endfunction

    // apply one request word to the model maps and give the result word
    function automatic t_slot_result pool_respond(
        input logic [1:0]                  action,
        input logic [rbsp_pkg::LEN_W-1:0]  length,
        input logic [rbsp_pkg::ADDR_W-1:0] address);
        t_slot_result r;
        int           idx;
        logic [32:0]  lo;
        logic [32:0]  hi;
        logic [32:0]  offset;
        r.status = rbsp_pkg::ST_OK;
        r.idx    = '0;
        r.addr   = '0;
        idx      = -1;
        case (action)
            rbsp_pkg::ACT_ALLOC: begin
                if (int'(length) + int'(mdl_header) > SLOT_BYTES) begin
                    r.status = rbsp_pkg::ST_TOO_LARGE;
                end else begin
                    idx = lowest_one(~mdl_used);
                    if (idx < 0) begin
                        r.status = rbsp_pkg::ST_FULL;
                    end else begin
                        mdl_used[idx]    = 1'b1;
                        mdl_pending[idx] = 1'b1;
                    end
                end
            end
            rbsp_pkg::ACT_FREE: begin
                // upper bound kept at 33 bits so a pool near the top does not wrap
                lo = {1'b0, mdl_base};
                hi = lo + 33'(SLOTS * SLOT_BYTES);
                if ({1'b0, address} < lo || {1'b0, address} >= hi) begin
                    r.status = rbsp_pkg::ST_BAD_ADDR;
                end else begin
                    offset        = {1'b0, address} - lo;
                    idx           = int'(offset / 33'(SLOT_BYTES));
                    mdl_used[idx] = 1'b0;
                end
            end
            default: begin
                idx = lowest_one(mdl_pending);
                if (idx < 0) begin
                    r.status = rbsp_pkg::ST_NONE;
                end else begin
                    mdl_pending[idx] = 1'b0;
                    mdl_used[idx]    = 1'b0;
                end
            end
        endcase
        if (r.status == rbsp_pkg::ST_OK) begin
            r.idx  = idx[rbsp_pkg::IDX_W-1:0];
            r.addr = mdl_base + 32'(idx * SLOT_BYTES);
        end
        return r;
    endfunction

    function automatic t_request random_request(input int alloc_w, input int free_w);
        t_request rq;
        int       pick;
        int       fit;
        fit  = SLOT_BYTES - int'(mdl_header);
        if (fit < 0) fit = 0;
        pick = $urandom_range(99, 0);
        if (pick < alloc_w)               rq.action = rbsp_pkg::ACT_ALLOC;
        else if (pick < alloc_w + free_w) rq.action = rbsp_pkg::ACT_FREE;
        else if (pick < 97)               rq.action = rbsp_pkg::ACT_TAKE;
        else                              rq.action = ACT_SPARE;

        pick = $urandom_range(9, 0);
        if (pick < 6)       rq.length = 16'($urandom_range(fit, 0));
        else if (pick == 6) rq.length = 16'(fit + $urandom_range(1, 0));
        else                rq.length = 16'($urandom());

        pick = $urandom_range(9, 0);
        case (pick)
            6:       rq.address = mdl_base - 32'd1;
            7:       rq.address = mdl_base + 32'(SLOTS * SLOT_BYTES);
            8:       rq.address = mdl_base + 32'(SLOTS * SLOT_BYTES - 1);
            9:       rq.address = $urandom();
            default: rq.address = mdl_base + 32'($urandom_range(SLOTS - 1, 0) * SLOT_BYTES)
                                  + 32'($urandom_range(SLOT_BYTES - 1, 0));
        endcase
        return rq;
    endfunction

    // capture accepted words and register writes, and predict
    always @(posedge i_clk) begin : word_capture
        t_override    tag;
        t_slot_result predicted;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == rbsp_pkg::CFG_POOL_BASE) mdl_base = i_cfg_data;
            else mdl_header = i_cfg_data[rbsp_pkg::HDR_W-1:0];
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            tag       = row_overrides.pop_front();
            predicted = pool_respond(i_s_tuser, i_s_tdata[15:0], i_s_tdata[47:16]);
            expected_results.push_back(tag.use_row ? tag.row_result : predicted);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (!$isunknown(o_m_tuser)) status_seen[o_m_tuser]++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: status %0d idx %0d addr %h",
                         $time, o_m_tuser, o_m_tdata[4:0], o_m_tdata[36:5]);
            end else begin
                want = expected_results.pop_front();
                if (o_m_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d", $time, want.status, o_m_tuser);
                end
                if (o_m_tdata[4:0] !== want.idx) begin
                    errors++;
                    $display("%0t: slot_index expected %0d, got %0d",
                             $time, want.idx, o_m_tdata[4:0]);
                end
                if (o_m_tdata[36:5] !== want.addr) begin
                    errors++;
                    $display("%0t: slot_address expected %h, got %h",
                             $time, want.addr, o_m_tdata[36:5]);
                end
            end
        end
    end

    // result side: random stalls, and a long hold when asked
    initial begin : sink_side
        int gap;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_sink = 1'b0;
            end else if (!calm && $urandom_range(4, 0) == 0) begin
                gap = $urandom_range(11, 1);
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_word(input logic [1:0] action,
                             input logic [rbsp_pkg::LEN_W-1:0] length,
                             input logic [rbsp_pkg::ADDR_W-1:0] address,
                             input bit use_row, input t_slot_result row_result);
        int gap;
        if (!calm && $urandom_range(4, 0) == 0) begin
            gap = $urandom_range(11, 1);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_overrides.push_back('{use_row, row_result});
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tdata  <= {address, length};
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
    endtask

    // hold off until every expected word is back, then let the pipe settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic configure_pool(input logic [31:0] base, input logic [31:0] header_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= rbsp_pkg::CFG_POOL_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= rbsp_pkg::CFG_HEADER;
        i_cfg_data  <= header_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
        // let the model take the new values before drawing requests
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input int alloc_w, input int free_w,
                             input int hold_at);
        t_request rq;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_sink = 1'b1;
            rq = random_request(alloc_w, free_w);
            send_word(rq.action, rq.length, rq.address, 1'b0, '0);
        end
        wait_idle();
    endtask

    initial begin : stimulus
        logic [31:0] noise;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= rbsp_pkg::CFG_POOL_BASE;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[k]) begin
            send_word(DIRECTED_ROWS[k].action, DIRECTED_ROWS[k].length,
                      DIRECTED_ROWS[k].address, DIRECTED_ROWS[k].use_row,
                      DIRECTED_ROWS[k].want);
        end
        wait_idle();

        // pool at the very top: slot addresses wrap, the free bound must not
        configure_pool(32'hFFFF_F800, 32'd0);
        run_phase(90, 40, 30, -1);

        // largest header: only empty packets fit
        configure_pool($urandom(), 32'd2048);
        run_phase(80, 45, 25, -1);

        // header past its range, upper data bits dropped
        noise = $urandom();
        configure_pool(32'd0, {noise[31:12], 12'hFFF});
        run_phase(40, 50, 20, -1);

        // allocate heavy with a long result hold: fills the pool and backs up
        configure_pool($urandom(), 32'($urandom_range(2048, 0)));
        run_phase(130, 80, 8, 30);

        // take heavy: drains to nothing pending
        configure_pool(32'hFFFF_FFFF, 32'(rbsp_pkg::HEADER_RESET));
        run_phase(90, 20, 20, -1);

        // last stretch at full rate
        calm  = 1'b1;
        noise = $urandom();
        configure_pool($urandom(), noise);
        run_phase(100, 45, 30, -1);

        repeat (RESULT_LATENCY * 4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            errors += expected_results.size();
            $display("%0t: %0d result words never arrived", $time, expected_results.size());
        end

        $display("Covered %0d request words over seven pool settings, %0d register writes",
                 words_sent, cfg_writes);
        $display("Results seen: ok %0d, too large %0d, full %0d, bad address %0d, none %0d",
                 status_seen[rbsp_pkg::ST_OK], status_seen[rbsp_pkg::ST_TOO_LARGE],
                 status_seen[rbsp_pkg::ST_FULL], status_seen[rbsp_pkg::ST_BAD_ADDR],
                 status_seen[rbsp_pkg::ST_NONE]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached, %0d words still expected",
                 $time, expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
